// ----- design/lgs_pkg.sv -----
package lgs_pkg;

  localparam int OP_W    = 2;
  localparam int ROW_W   = 5;
  localparam int COL_W   = 5;
  localparam int SIDE_W  = 6;
  localparam int COUNT_W = 11;
  localparam int IDX_W   = SIDE_W + 1;
  localparam int NB_W    = 4;

  localparam logic [SIDE_W-1:0]  SIDE_RESET    = 6'd25;
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
  localparam logic [NB_W-1:0]    BIRTH_COUNT   = 4'd3;
  localparam logic [NB_W-1:0]    SURVIVE_COUNT = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CELL,
    S_STEP
  } state_t;

endpackage

// ----- design/lgs_in_if.sv -----
interface lgs_in_if;
  import lgs_pkg::*;

  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    opcode;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic               value;

  modport source (output valid, opcode, row, col, value, input ready);
  modport sink   (input valid, opcode, row, col, value, output ready);
endinterface

// ----- design/lgs_out_if.sv -----
interface lgs_out_if;
  import lgs_pkg::*;

  logic               valid;
  logic               ready;
  logic               cell_value;
  logic [COUNT_W-1:0] changed_count;

  modport source (output valid, cell_value, changed_count, input ready);
  modport sink   (input valid, cell_value, changed_count, output ready);
endinterface

// ----- design/life_grid_generation_step.sv -----
// channel   dir  handshake        payload
// in_ch     in   valid / ready    opcode, row, col, value
// out_ch    out  valid / ready    cell_value, changed_count
// cfg       in   cfg_wr_en        cfg_wr_data (board side)
//
// a write or read item is a registered row read, then the read-modify-write or
// bit select on the grid memory.
// a step reads one row a cycle, the shared row update unit writing back two
// rows behind, then gives a final count.
// reset clears the board side to 25 and all rows through per-row valid bits.
// a result waits in the output register; the next item is taken once it goes.
module life_grid_generation_step #(
  parameter int MAX_SIDE = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [lgs_pkg::SIDE_W-1:0] cfg_wr_data,
  lgs_in_if.sink                     in_ch,
  lgs_out_if.source                  out_ch
);
  import lgs_pkg::*;

  localparam int RW    = $clog2(MAX_SIDE);
  localparam int DEPTH = 1 << RW;
  localparam int PW    = $clog2(MAX_SIDE + 1);

  state_t               state_r, state_nxt;
  logic [SIDE_W-1:0]    side_r;
  logic [SIDE_W-1:0]    side_use;
  logic [MAX_SIDE-1:0]  mask;

  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [OP_W-1:0]      op_r, op_nxt;
  logic [RW-1:0]        row_r, row_nxt;
  logic [COL_W-1:0]     col_r, col_nxt;
  logic                 val_r, val_nxt;
  logic                 inside_r, inside_nxt;

  logic [MAX_SIDE-1:0]  win_above_r, win_above_nxt;
  logic [MAX_SIDE-1:0]  win_cur_r, win_cur_nxt;
  logic [MAX_SIDE-1:0]  diff_r, diff_nxt;
  logic [COUNT_W-1:0]   acc_r, acc_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_cell_r, out_cell_nxt;
  logic [COUNT_W-1:0]   out_count_r, out_count_nxt;

  logic [MAX_SIDE-1:0]  mem [DEPTH];
  logic [DEPTH-1:0]     row_vld_r;
  logic [MAX_SIDE-1:0]  rd_q_r;
  logic [RW-1:0]        rd_addr;
  logic                 mem_we;
  logic [RW-1:0]        mem_waddr;
  logic [MAX_SIDE-1:0]  mem_wdata;

  logic [MAX_SIDE-1:0]  above_m, cur_m, below_m, below_raw;
  logic [MAX_SIDE+1:0]  above_x, cur_x, below_x;
  logic [MAX_SIDE-1:0]  next_row, diff_row;
  logic [MAX_SIDE-1:0]  cell_sh;
  logic [PW-1:0]        pop;
  logic [COUNT_W:0]     acc_sum;
  logic [IDX_W-1:0]     idx_m2;
  logic [IDX_W-1:0]     side_x;
  logic                 below_on, calc_on;
  logic                 in_xfer;

  function automatic logic [NB_W-1:0] nb_count(input logic [2:0] a, input logic [2:0] m,
                                                input logic [2:0] b);
    logic [NB_W-1:0] s;
    s = NB_W'(m[0]) + NB_W'(m[2]);
    for (int k = 0; k < 3; k++) begin
      s = s + NB_W'(a[k]) + NB_W'(b[k]);
    end
    return s;
  endfunction

  // side in use saturates at the grid size
  assign side_use = ({1'b0, side_r} > IDX_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE) : side_r;
  assign side_x   = {1'b0, side_use};

  always_comb begin
    for (int c = 0; c < MAX_SIDE; c++) begin
      mask[c] = (IDX_W'(c) < side_x);
    end
  end

  // row update unit
  assign below_on  = (idx_r != '0) && (idx_r <= side_x);
  assign calc_on   = (idx_r >= IDX_W'(2)) && (idx_r <= side_x + IDX_W'(1));
  assign below_raw = below_on ? rd_q_r : '0;
  assign above_m   = win_above_r & mask;
  assign cur_m     = win_cur_r & mask;
  assign below_m   = below_raw & mask;
  assign above_x   = {1'b0, above_m, 1'b0};
  assign cur_x     = {1'b0, cur_m, 1'b0};
  assign below_x   = {1'b0, below_m, 1'b0};

  always_comb begin
    logic [NB_W-1:0] cnt;
    for (int c = 0; c < MAX_SIDE; c++) begin
      cnt = nb_count(above_x[c +: 3], cur_x[c +: 3], below_x[c +: 3]);
      next_row[c] = mask[c] & ((cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && cur_m[c]));
    end
  end

  assign diff_row = next_row ^ cur_m;
  assign pop      = PW'($countones(diff_r));
  assign acc_sum  = {1'b0, acc_r} + (COUNT_W + 1)'(pop);
  assign idx_m2   = idx_r - IDX_W'(2);
  assign cell_sh  = rd_q_r >> col_r;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  assign in_ch.ready          = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.cell_value    = out_cell_r;
  assign out_ch.changed_count = out_count_r;

  always_comb begin
    logic [IDX_W-1:0] row_x;
    row_x         = {2'b00, in_ch.row};
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    val_nxt       = val_r;
    inside_nxt    = inside_r;
    win_above_nxt = win_above_r;
    win_cur_nxt   = win_cur_r;
    diff_nxt      = '0;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_cell_nxt  = out_cell_r;
    out_count_nxt = out_count_r;
    rd_addr       = idx_r[RW-1:0];
    mem_we        = 1'b0;
    mem_waddr     = row_r;
    mem_wdata     = rd_q_r;
    case (state_r)
      S_IDLE: begin
        rd_addr = row_x[RW-1:0];
        if (in_xfer) begin
          op_nxt     = in_ch.opcode;
          row_nxt    = row_x[RW-1:0];
          col_nxt    = in_ch.col;
          val_nxt    = in_ch.value;
          inside_nxt = ({1'b0, in_ch.row} < side_use) && ({1'b0, in_ch.col} < side_use);
          idx_nxt       = '0;
          acc_nxt       = '0;
          win_above_nxt = '0;
          win_cur_nxt   = '0;
          state_nxt     = (in_ch.opcode == OP_STEP) ? S_STEP : S_CELL;
        end
      end
      S_CELL: begin
        if ((op_r == OP_WRITE) && inside_r) begin
          mem_we    = 1'b1;
          mem_wdata = (rd_q_r & ~(MAX_SIDE'(1) << col_r)) | (MAX_SIDE'(val_r) << col_r);
        end
        out_valid_nxt = 1'b1;
        out_cell_nxt  = (op_r == OP_READ) && inside_r && cell_sh[0];
        out_count_nxt = '0;
        state_nxt     = S_IDLE;
      end
      S_STEP: begin
        if (idx_r != '0) begin
          win_above_nxt = win_cur_r;
          win_cur_nxt   = below_raw;
        end
        if (calc_on) begin
          mem_we    = 1'b1;
          mem_waddr = idx_m2[RW-1:0];
          mem_wdata = (win_cur_r & ~mask) | next_row;
          diff_nxt  = diff_row;
        end
        acc_nxt = acc_sum[COUNT_W] ? COUNT_MAX : acc_sum[COUNT_W-1:0];
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == side_x + IDX_W'(2)) begin
          out_valid_nxt = 1'b1;
          out_cell_nxt  = 1'b0;
          out_count_nxt = acc_nxt;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      side_r      <= SIDE_RESET;
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
      if (cfg_wr_en) begin
        side_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    row_r       <= row_nxt;
    col_r       <= col_nxt;
    val_r       <= val_nxt;
    inside_r    <= inside_nxt;
    win_above_r <= win_above_nxt;
    win_cur_r   <= win_cur_nxt;
    diff_r      <= diff_nxt;
    acc_r       <= acc_nxt;
    out_cell_r  <= out_cell_nxt;
    out_count_r <= out_count_nxt;
  end

  // grid memory, rows never written read as dead
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q_r <= row_vld_r[rd_addr] ? mem[rd_addr] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (mem_we) begin
      row_vld_r[mem_waddr] <= 1'b1;
    end
  end

endmodule

// ----- design/lgs_checker.sv -----
module lgs_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [lgs_pkg::OP_W-1:0]    in_opcode,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        out_cell_value,
  input logic [lgs_pkg::COUNT_W-1:0] out_changed_count
);
  import lgs_pkg::*;

  // one item at a time
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a transfer");

  // cell items answer after the registered row read and the cell state
  a_cell_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_opcode != OP_STEP) |=> ##1 out_valid)
    else $error("cell item result late");

  a_read_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_cell_value |-> out_changed_count == '0)
    else $error("read result carries a change count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_cell_value) && $stable(out_changed_count))
    else $error("result changed while stalled");

endmodule

bind life_grid_generation_step lgs_checker u_lgs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .in_opcode         (in_ch.opcode),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_cell_value    (out_ch.cell_value),
  .out_changed_count (out_ch.changed_count)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import lgs_pkg::*;

  localparam int BOARD_MAX      = 32;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic               cell_value;
    logic [COUNT_W-1:0] changed_count;
  } life_result_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [SIDE_W-1:0] cfg_wr_data;

  lgs_in_if  in_ch ();
  lgs_out_if out_ch ();

  life_grid_generation_step u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // own copy of the grid and the side register
  logic [BOARD_MAX-1:0] board_cells [BOARD_MAX];
  logic [SIDE_W-1:0]    board_side;

  life_result_t pending_results [$];
  life_result_t checked_want;

  bit idle_on;
  bit hold_request;
  int fail_count;
  int results_checked;
  int items_sent;
  int steps_sent;
  int sides_used;
  int quiet_cycles;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int side_limit();
    return (board_side > BOARD_MAX) ? BOARD_MAX : int'(board_side);
  endfunction

  function automatic int cell_at(logic [BOARD_MAX-1:0] cells, int c);
    if (c < 0 || c >= BOARD_MAX) return 0;
    return int'(cells[c]);
  endfunction

  function automatic logic [COUNT_W-1:0] advance_board();
    int side;
    int r;
    int c;
    int neighbours;
    int changed;
    logic [BOARD_MAX-1:0] mask;
    logic [BOARD_MAX-1:0] above;
    logic [BOARD_MAX-1:0] cur;
    logic [BOARD_MAX-1:0] below;
    logic [BOARD_MAX-1:0] next_row;
    logic self_live;
    logic live;
    side = side_limit();
    mask = (side >= BOARD_MAX) ? '1 : ((BOARD_MAX'(1) << side) - 1'b1);
    changed = 0;
    above = '0;
    cur = (side > 0) ? (board_cells[0] & mask) : '0;
    for (r = 0; r < side; r++) begin
      below = (r + 1 < side) ? (board_cells[r + 1] & mask) : '0;
      next_row = '0;
      for (c = 0; c < side; c++) begin
        neighbours = cell_at(above, c - 1) + cell_at(above, c) + cell_at(above, c + 1)
                   + cell_at(cur, c - 1) + cell_at(cur, c + 1)
                   + cell_at(below, c - 1) + cell_at(below, c) + cell_at(below, c + 1);
        self_live = cur[c];
        if (neighbours == int'(BIRTH_COUNT)) live = 1'b1;
        else if (neighbours == int'(SURVIVE_COUNT)) live = self_live;
        else live = 1'b0;
        if (live != self_live) changed++;
        next_row[c] = live;
      end
      board_cells[r] = (board_cells[r] & ~mask) | next_row;
      above = cur;
      cur = below;
    end
    if (changed > int'(COUNT_MAX)) changed = int'(COUNT_MAX);
    return COUNT_W'(changed);
  endfunction

  function automatic life_result_t apply_item(logic [OP_W-1:0] opcode, logic [ROW_W-1:0] row,
                                              logic [COL_W-1:0] col, logic value);
    life_result_t res;
    bit on_board;
    res = '0;
    on_board = (int'(row) < side_limit()) && (int'(col) < side_limit());
    if (opcode == OP_WRITE) begin
      if (on_board) board_cells[row][col] = value;
    end else if (opcode == OP_READ) begin
      if (on_board) res.cell_value = board_cells[row][col];
    end else if (opcode == OP_STEP) begin
      res.changed_count = advance_board();
    end
    return res;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] opcode, input logic [ROW_W-1:0] row,
                           input logic [COL_W-1:0] col, input logic value);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(0, 15)) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= opcode;
    in_ch.row    <= row;
    in_ch.col    <= col;
    in_ch.value  <= value;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_item(opcode, row, col, value));
    items_sent++;
    if (opcode == OP_STEP) steps_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_side(input logic [SIDE_W-1:0] side);
    wait_drained();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= side;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    board_side = side;
    sides_used++;
  endtask

  task automatic send_random_item();
    int side;
    int pick;
    logic [OP_W-1:0]  opcode;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    side = side_limit();
    pick = $urandom_range(0, 99);
    if (pick < 50) opcode = OP_WRITE;
    else if (pick < 78) opcode = OP_READ;
    else if (pick < 94) opcode = OP_STEP;
    else opcode = OP_UNUSED;
    // mostly cells on the board, so that patterns build up between steps
    if (side > 0 && $urandom_range(0, 7) != 0) begin
      row = ROW_W'($urandom_range(0, side - 1));
      col = COL_W'($urandom_range(0, side - 1));
    end else begin
      row = ROW_W'($urandom);
      col = COL_W'($urandom);
    end
    send_item(opcode, row, col, $urandom_range(0, 3) != 0);
  endtask

  task automatic test_reset_state();
    send_item(OP_READ, 5'd0, 5'd0, 1'b0);
    send_item(OP_READ, 5'd24, 5'd24, 1'b0);
    send_item(OP_STEP, 5'd0, 5'd0, 1'b0);
  endtask

  task automatic test_cell_access();
    send_item(OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_item(OP_READ, 5'd0, 5'd0, 1'b0);
    send_item(OP_WRITE, 5'd24, 5'd24, 1'b1);
    send_item(OP_READ, 5'd24, 5'd24, 1'b0);
    send_item(OP_WRITE, 5'd25, 5'd3, 1'b1);
    send_item(OP_READ, 5'd25, 5'd3, 1'b0);
    send_item(OP_WRITE, 5'd3, 5'd31, 1'b1);
    send_item(OP_READ, 5'd3, 5'd31, 1'b0);
    send_item(OP_UNUSED, 5'd31, 5'd31, 1'b1);
  endtask

  task automatic test_blinker();
    send_item(OP_WRITE, 5'd5, 5'd4, 1'b1);
    send_item(OP_WRITE, 5'd5, 5'd5, 1'b1);
    send_item(OP_WRITE, 5'd5, 5'd6, 1'b1);
    send_item(OP_STEP, 5'd0, 5'd0, 1'b0);
    send_item(OP_READ, 5'd4, 5'd5, 1'b0);
  endtask

  task automatic test_side_extremes();
    set_side(6'd0);
    send_item(OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_item(OP_STEP, 5'd0, 5'd0, 1'b0);
    set_side(6'd63);
    send_item(OP_WRITE, 5'd31, 5'd31, 1'b1);
    send_item(OP_WRITE, 5'd31, 5'd30, 1'b1);
    send_item(OP_WRITE, 5'd30, 5'd31, 1'b1);
    send_item(OP_STEP, 5'd0, 5'd0, 1'b0);
    set_side(6'd1);
    send_item(OP_WRITE, 5'd0, 5'd0, 1'b1);
    send_item(OP_STEP, 5'd0, 5'd0, 1'b0);
    // cells past the side in use must survive a step untouched
    set_side(6'd20);
    send_item(OP_STEP, 5'd0, 5'd0, 1'b0);
    set_side(6'd32);
    send_item(OP_READ, 5'd30, 5'd30, 1'b0);
  endtask

  task automatic test_random_boards();
    logic [SIDE_W-1:0] sides [12];
    int i;
    sides = '{6'd32, 6'd5, 6'd63, 6'd1, 6'd2, 6'd3, 6'd0, 6'd33,
              SIDE_W'($urandom_range(4, 31)), SIDE_W'($urandom_range(4, 31)), 6'd16, 6'd25};
    for (i = 0; i < 12; i++) begin
      set_side(sides[i]);
      repeat (45) send_random_item();
    end
  endtask

  task automatic test_output_hold();
    idle_on = 1'b0;
    set_side(6'd8);
    hold_request = 1'b1;
    repeat (12) send_random_item();
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_drained_pauses();
    repeat (20) begin
      send_random_item();
      wait_drained();
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    set_side(6'd12);
    repeat (60) send_random_item();
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: transfer with no result pending: cell_value %0d changed_count %0d",
                 $time, out_ch.cell_value, out_ch.changed_count);
        fail_count++;
      end else begin
        checked_want = pending_results.pop_front();
        results_checked++;
        if (out_ch.cell_value !== checked_want.cell_value) begin
          $display("%0t: cell_value expected %0d actual %0d",
                   $time, checked_want.cell_value, out_ch.cell_value);
          fail_count++;
        end
        if (out_ch.changed_count !== checked_want.changed_count) begin
          $display("%0t: changed_count expected %0d actual %0d",
                   $time, checked_want.changed_count, out_ch.changed_count);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results pending",
                 $time, WATCHDOG_LIMIT, pending_results.size());
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = '0;
    in_ch.valid  = 1'b0;
    in_ch.opcode = '0;
    in_ch.row    = '0;
    in_ch.col    = '0;
    in_ch.value  = 1'b0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    quiet_cycles = 0;
    board_side   = SIDE_RESET;
    foreach (board_cells[i]) board_cells[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_cell_access();
    test_blinker();
    test_side_extremes();
    test_random_boards();
    test_output_hold();
    test_drained_pauses();
    test_full_rate();

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d items (%0d generation steps) over %0d board side settings",
             items_sent, steps_sent, sides_used);
    $display("%0d results checked, %0d mismatches", results_checked, fail_count);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ----- life_grid_generation_step.f -----
design/lgs_pkg.sv
design/lgs_in_if.sv
design/lgs_out_if.sv
design/life_grid_generation_step.sv
design/lgs_checker.sv
tb/testbench.sv
